// ===== hw/rtl/kftdc_pkg.sv =====
package kftdc_pkg;

	localparam int NUM_FIBERS = 256;
	localparam int HIT_FIELDS = 6;
	localparam int HITS_PER_FIBER = 6;
	localparam int HITS_USED = (HITS_PER_FIBER < HIT_FIELDS) ? HITS_PER_FIBER : HIT_FIELDS;
	localparam int QUEUE_DEPTH = 2;

	localparam int ADC_W = 13;
	localparam int TDC_W = 12;
	localparam int FIB_W = 8;
	localparam int CFG_W = 13;
	localparam int CFG_ADDR_W = 3;
	localparam int IN_DATA_W = 104;
	localparam int OUT_DATA_W = 24;

	localparam logic [FIB_W-1:0] LAST_INDEX = FIB_W'(NUM_FIBERS - 1);
	localparam logic signed [ADC_W-1:0] NONE_LEVEL = -13'sd100;

	localparam logic [CFG_ADDR_W-1:0] REG_HIGH_GAIN_THR = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LOW_GAIN_THR = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_MIN = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_MAX = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_AGREE_LIMIT = 3'd4;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ONE = 2'd1;
	localparam logic [1:0] KIND_MANY = 2'd2;

	typedef struct packed {
		logic signed [ADC_W-1:0] high_gain_threshold;
		logic signed [ADC_W-1:0] low_gain_threshold;
		logic [TDC_W-1:0] window_min;
		logic [TDC_W-1:0] window_max;
		logic [TDC_W-1:0] agree_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [ADC_W-1:0] adc_high;
		logic signed [ADC_W-1:0] adc_low;
		logic [TDC_W-1:0] kept;
		logic [FIB_W-1:0] fiber;
		logic has_hit;
		logic cand;
		logic ends;
	} item_t;

endpackage

// ===== hw/rtl/kaon_fiber_tdc_select_unit.sv =====
// Channel    Direction  Word                                       Side band
// s_axis     in         adc_high, adc_low, tdc_hit_0..tdc_hit_5    tlast = last_fiber
// m_axis     out        tdc_time, substitute_fiber                 tuser = case_kind
// cfg        in         register index and write data              none
//
// One fiber word is taken in every cycle while the result side keeps up.
// A fiber passes through the classification register, then the queue, where an event end
// waits for a free result slot, and then the running top-two update; an event end's
// totals go to a snapshot register and from there to the registered result.
// Reset clears the registers to their defaults and the event state; no clearing pass.
// A stalled result holds back the next event end and the fibers behind it, never the fibers before it.
module kaon_fiber_tdc_select_unit import kftdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_ADDR_W-1:0] cfg_addr,
	input logic [CFG_W-1:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// adc_high[12:0], adc_low[25:13], tdc_hit_0..tdc_hit_5 12 bits each from bit 26, zero pad
	input logic [IN_DATA_W-1:0] s_axis_tdata,
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdc_time[12:0], substitute_fiber[21:13], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// case_kind[1:0]
	output logic [1:0] m_axis_tuser
);

	cfg_t cfg_q;
	logic push;
	item_t push_item;
	logic queue_full;
	logic pop;
	logic not_empty;
	item_t head;
	logic signed [ADC_W-1:0] tdc_time;
	logic signed [FIB_W:0] substitute_fiber;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_gain_threshold <= '0;
			cfg_q.low_gain_threshold <= '0;
			cfg_q.window_min <= '0;
			cfg_q.window_max <= 12'd4095;
			cfg_q.agree_limit <= 12'd3;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HIGH_GAIN_THR: cfg_q.high_gain_threshold <= cfg_wdata[ADC_W-1:0];
				REG_LOW_GAIN_THR: cfg_q.low_gain_threshold <= cfg_wdata[ADC_W-1:0];
				REG_WINDOW_MIN: cfg_q.window_min <= cfg_wdata[TDC_W-1:0];
				REG_WINDOW_MAX: cfg_q.window_max <= cfg_wdata[TDC_W-1:0];
				REG_AGREE_LIMIT: cfg_q.agree_limit <= cfg_wdata[TDC_W-1:0];
				default: ;
			endcase
		end
	end

	kftdc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_data(s_axis_tdata),
		.in_last(s_axis_tlast),
		.push(push),
		.push_item(push_item),
		.queue_full(queue_full)
	);

	kftdc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(queue_full),
		.pop(pop),
		.not_empty(not_empty),
		.head(head)
	);

	kftdc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.not_empty(not_empty),
		.head(head),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.tdc_time(tdc_time),
		.substitute_fiber(substitute_fiber),
		.case_kind(m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, substitute_fiber, tdc_time};

endmodule

// ===== hw/rtl/kftdc_front.sv =====
module kftdc_front import kftdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic [IN_DATA_W-1:0] in_data,
	input logic in_last,
	output logic push,
	output item_t push_item,
	input logic queue_full
);

	logic [FIB_W-1:0] idx_q;
	logic valid_s1;
	item_t item_s1;
	item_t item_c;
	logic accept;

	always_comb begin
		logic [TDC_W-1:0] t;
		item_c = '0;
		item_c.adc_high = in_data[ADC_W-1:0];
		item_c.adc_low = in_data[2*ADC_W-1:ADC_W];
		item_c.fiber = idx_q;
		for (int j = 0; j < HITS_USED; j++) begin
			t = in_data[2*ADC_W + j*TDC_W +: TDC_W];
			if (t >= cfg.window_min && t <= cfg.window_max) begin
				item_c.has_hit = 1'b1;
				item_c.kept = t;
			end
		end
		item_c.cand = item_c.has_hit && (item_c.adc_high > cfg.high_gain_threshold);
		item_c.ends = in_last || (idx_q == LAST_INDEX);
	end

	assign push = valid_s1 && !queue_full;
	assign push_item = item_s1;
	assign in_ready = !valid_s1 || !queue_full;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= item_c.ends ? '0 : idx_q + 1'b1;
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule

// ===== hw/rtl/kftdc_queue.sv =====
module kftdc_queue import kftdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t push_item,
	output logic full,
	input logic pop,
	output logic not_empty,
	output item_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = slots_q[rd_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== hw/rtl/kftdc_back.sv =====
module kftdc_back import kftdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic not_empty,
	input item_t head,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic signed [ADC_W-1:0] tdc_time,
	output logic signed [FIB_W:0] substitute_fiber,
	output logic [1:0] case_kind
);

	typedef struct packed {
		logic [1:0] count;
		logic signed [ADC_W-1:0] t1_adc;
		logic [FIB_W-1:0] t1_fiber;
		logic [TDC_W-1:0] t1_tdc;
		logic signed [ADC_W-1:0] t2_adc;
		logic [FIB_W-1:0] t2_fiber;
		logic [TDC_W-1:0] t2_tdc;
		logic signed [ADC_W-1:0] fb_adc;
		logic [FIB_W-1:0] fb_fiber;
		logic [TDC_W-1:0] fb_tdc;
		logic fb_found;
	} acc_t;

	localparam acc_t ACC_CLEAR = '{
		count: '0, t1_adc: NONE_LEVEL, t1_fiber: '0, t1_tdc: '0,
		t2_adc: NONE_LEVEL, t2_fiber: '0, t2_tdc: '0,
		fb_adc: NONE_LEVEL, fb_fiber: '0, fb_tdc: '0, fb_found: 1'b0
	};

	acc_t acc_q;
	acc_t acc_next;
	acc_t snap_s1;
	logic snap_valid_s1;
	logic snap_move;
	logic snap_free;

	logic signed [ADC_W-1:0] time_c;
	logic signed [FIB_W:0] sub_c;

	always_comb begin
		acc_next = acc_q;
		if (head.cand) begin
			if (acc_q.count == 2'd0) begin
				acc_next.t1_adc = head.adc_low;
				acc_next.t1_fiber = head.fiber;
				acc_next.t1_tdc = head.kept;
			end else if (head.adc_low > NONE_LEVEL && head.adc_low > acc_q.t1_adc) begin
				acc_next.t2_adc = acc_q.t1_adc;
				acc_next.t2_fiber = acc_q.t1_fiber;
				acc_next.t2_tdc = acc_q.t1_tdc;
				acc_next.t1_adc = head.adc_low;
				acc_next.t1_fiber = head.fiber;
				acc_next.t1_tdc = head.kept;
			end else if (head.adc_low > NONE_LEVEL && head.adc_low > acc_q.t2_adc) begin
				acc_next.t2_adc = head.adc_low;
				acc_next.t2_fiber = head.fiber;
				acc_next.t2_tdc = head.kept;
			end
			if (acc_q.count != 2'd2) begin
				acc_next.count = acc_q.count + 1'b1;
			end
		end
		if (head.has_hit && head.adc_high > acc_q.fb_adc) begin
			acc_next.fb_adc = head.adc_high;
			acc_next.fb_fiber = head.fiber;
			acc_next.fb_tdc = head.kept;
			acc_next.fb_found = 1'b1;
		end
	end

	assign snap_move = snap_valid_s1 && (!out_valid || out_ready);
	assign snap_free = !snap_valid_s1 || snap_move;
	assign pop = not_empty && (!head.ends || snap_free);

	always_comb begin
		logic v1;
		logic v2;
		logic signed [ADC_W-1:0] m1;
		logic signed [ADC_W-1:0] m2;
		logic signed [ADC_W-1:0] t1;
		logic signed [ADC_W-1:0] t2;
		logic signed [ADC_W:0] diff;
		logic signed [ADC_W:0] sum;
		logic signed [ADC_W:0] half;
		logic [ADC_W:0] spread;
		v1 = snap_s1.t1_adc > NONE_LEVEL;
		v2 = v1 && (snap_s1.t2_adc > NONE_LEVEL);
		m1 = v1 ? snap_s1.t1_adc : NONE_LEVEL;
		m2 = v2 ? snap_s1.t2_adc : NONE_LEVEL;
		t1 = v1 ? $signed({1'b0, snap_s1.t1_tdc}) : -13'sd1;
		t2 = v2 ? $signed({1'b0, snap_s1.t2_tdc}) : -13'sd1;
		diff = (ADC_W+1)'(t1) - (ADC_W+1)'(t2);
		spread = diff[ADC_W] ? $unsigned(-diff) : $unsigned(diff);
		sum = (ADC_W+1)'(t1) + (ADC_W+1)'(t2);
		half = sum[ADC_W] ? ((sum + $signed((ADC_W+1)'(1))) >>> 1) : (sum >>> 1);
		time_c = -13'sd1;
		sub_c = -9'sd1;
		unique case (snap_s1.count)
			KIND_NONE: begin
				if (snap_s1.fb_found) begin
					time_c = $signed({1'b0, snap_s1.fb_tdc});
					sub_c = $signed({1'b0, snap_s1.fb_fiber});
				end
			end
			KIND_ONE: begin
				time_c = $signed({1'b0, snap_s1.t1_tdc});
				if (snap_s1.t1_adc < cfg.low_gain_threshold) begin
					sub_c = $signed({1'b0, snap_s1.t1_fiber});
				end
			end
			default: begin
				if (spread <= {2'b00, cfg.agree_limit}) begin
					time_c = half[ADC_W-1:0];
				end else if (m1 > m2) begin
					time_c = t1;
				end else if (m1 < m2) begin
					time_c = t2;
				end
				if (v1 && m1 < cfg.low_gain_threshold) begin
					sub_c = $signed({1'b0, snap_s1.t1_fiber});
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= ACC_CLEAR;
			snap_valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= head.ends ? ACC_CLEAR : acc_next;
			end
			if (pop && head.ends) begin
				snap_valid_s1 <= 1'b1;
			end else if (snap_move) begin
				snap_valid_s1 <= 1'b0;
			end
			if (snap_move) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.ends) begin
			snap_s1 <= acc_next;
		end
		if (snap_move) begin
			tdc_time <= time_c;
			substitute_fiber <= sub_c;
			case_kind <= snap_s1.count;
		end
	end

endmodule

// ===== dv/kaon_fiber_tdc_select_checker.sv =====
`timescale 1ns / 100ps

module kaon_fiber_tdc_select_checker import kftdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_ADDR_W-1:0] cfg_addr,
	input logic [CFG_W-1:0] cfg_wdata,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	// adc_high[12:0], adc_low[25:13], tdc_hit_0..tdc_hit_5 12 bits each from bit 26, zero pad
	input logic [IN_DATA_W-1:0] s_axis_tdata,
	input logic s_axis_tlast,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdc_time[12:0], substitute_fiber[21:13], zero pad
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	// case_kind[1:0]
	input logic [1:0] m_axis_tuser,
	output int fail_count,
	output int pending
);

	typedef struct packed {
		logic signed [12:0] tdc_time;
		logic signed [8:0] substitute_fiber;
		logic [1:0] case_kind;
	} selection_t;

	cfg_t regs;
	selection_t selection_q[$];

	logic [FIB_W-1:0] fiber_idx;
	logic [1:0] cand_count;
	logic signed [ADC_W-1:0] first_adc;
	logic signed [ADC_W-1:0] second_adc;
	logic signed [ADC_W-1:0] backup_adc;
	logic [FIB_W-1:0] first_fiber;
	logic [FIB_W-1:0] second_fiber;
	logic [FIB_W-1:0] backup_fiber;
	logic [TDC_W-1:0] first_tdc;
	logic [TDC_W-1:0] second_tdc;
	logic [TDC_W-1:0] backup_tdc;
	logic backup_found;
	int fails;
	int reported;

	task automatic clear_event();
		fiber_idx = '0;
		cand_count = KIND_NONE;
		first_adc = NONE_LEVEL;
		first_fiber = '0;
		first_tdc = '0;
		second_adc = NONE_LEVEL;
		second_fiber = '0;
		second_tdc = '0;
		backup_adc = NONE_LEVEL;
		backup_fiber = '0;
		backup_tdc = '0;
		backup_found = 1'b0;
	endtask

	task automatic note_failure(input string msg);
		fails++;
		if (reported < 10) begin
			reported++;
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// Folds one fiber word into the running event and queues the selection
	// when the word closes the event.
	task automatic absorb_fiber(input logic [IN_DATA_W-1:0] word, input logic last);
		logic signed [ADC_W-1:0] hg;
		logic signed [ADC_W-1:0] lg;
		logic [TDC_W-1:0] hit;
		logic [TDC_W-1:0] kept;
		logic in_win;
		logic v1;
		logic v2;
		int j;
		int m1;
		int m2;
		int t1;
		int t2;
		int d;
		int t_out;
		int f_out;
		selection_t sel;
		hg = word[12:0];
		lg = word[25:13];
		in_win = 1'b0;
		kept = '0;
		for (j = 0; j < HITS_USED; j++) begin
			hit = word[26 + 12 * j +: 12];
			if (hit >= regs.window_min && hit <= regs.window_max) begin
				in_win = 1'b1;
				kept = hit;
			end
		end
		if (in_win && hg > regs.high_gain_threshold) begin
			if (cand_count == KIND_NONE) begin
				first_adc = lg;
				first_fiber = fiber_idx;
				first_tdc = kept;
			end else if (lg > NONE_LEVEL && lg > first_adc) begin
				second_adc = first_adc;
				second_fiber = first_fiber;
				second_tdc = first_tdc;
				first_adc = lg;
				first_fiber = fiber_idx;
				first_tdc = kept;
			end else if (lg > NONE_LEVEL && lg > second_adc) begin
				second_adc = lg;
				second_fiber = fiber_idx;
				second_tdc = kept;
			end
			if (cand_count != KIND_MANY)
				cand_count = cand_count + 2'd1;
		end
		if (in_win && hg > backup_adc) begin
			backup_adc = hg;
			backup_fiber = fiber_idx;
			backup_tdc = kept;
			backup_found = 1'b1;
		end
		if (!last && fiber_idx != LAST_INDEX) begin
			fiber_idx = fiber_idx + 1'b1;
		end else begin
			t_out = -1;
			f_out = -1;
			if (cand_count == KIND_NONE) begin
				if (backup_found) begin
					t_out = int'(backup_tdc);
					f_out = int'(backup_fiber);
				end
			end else if (cand_count == KIND_ONE) begin
				t_out = int'(first_tdc);
				if (first_adc < regs.low_gain_threshold)
					f_out = int'(first_fiber);
			end else begin
				v1 = first_adc > NONE_LEVEL;
				v2 = v1 && (second_adc > NONE_LEVEL);
				m1 = v1 ? int'(first_adc) : int'(NONE_LEVEL);
				m2 = v2 ? int'(second_adc) : int'(NONE_LEVEL);
				t1 = v1 ? int'(first_tdc) : -1;
				t2 = v2 ? int'(second_tdc) : -1;
				d = t1 - t2;
				if (d < 0)
					d = -d;
				if (d <= int'(regs.agree_limit))
					t_out = (t1 + t2) / 2;
				else if (m1 > m2)
					t_out = t1;
				else if (m1 < m2)
					t_out = t2;
				else
					t_out = -1;
				if (v1 && first_adc < regs.low_gain_threshold)
					f_out = int'(first_fiber);
			end
			sel.tdc_time = t_out[12:0];
			sel.substitute_fiber = f_out[8:0];
			sel.case_kind = cand_count;
			selection_q.insert(selection_q.size(), sel);
			clear_event();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		selection_t got;
		selection_t want;
		if (!arst_n) begin
			regs.high_gain_threshold = '0;
			regs.low_gain_threshold = '0;
			regs.window_min = '0;
			regs.window_max = '1;
			regs.agree_limit = 12'd3;
			clear_event();
			selection_q.delete();
			fails = 0;
			reported = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_HIGH_GAIN_THR: regs.high_gain_threshold = cfg_wdata;
					REG_LOW_GAIN_THR: regs.low_gain_threshold = cfg_wdata;
					REG_WINDOW_MIN: regs.window_min = cfg_wdata[TDC_W-1:0];
					REG_WINDOW_MAX: regs.window_max = cfg_wdata[TDC_W-1:0];
					REG_AGREE_LIMIT: regs.agree_limit = cfg_wdata[TDC_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.tdc_time = m_axis_tdata[12:0];
				got.substitute_fiber = m_axis_tdata[21:13];
				got.case_kind = m_axis_tuser;
				if (selection_q.size() == 0) begin
					note_failure($sformatf("unexpected word: time %0d fiber %0d kind %0d",
						got.tdc_time, got.substitute_fiber, got.case_kind));
				end else begin
					want = selection_q.pop_front();
					if (got.tdc_time !== want.tdc_time
							|| got.substitute_fiber !== want.substitute_fiber
							|| got.case_kind !== want.case_kind)
						note_failure($sformatf(
							"mismatch: expected time %0d fiber %0d kind %0d, got time %0d fiber %0d kind %0d",
							want.tdc_time, want.substitute_fiber, want.case_kind,
							got.tdc_time, got.substitute_fiber, got.case_kind));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_fiber(s_axis_tdata, s_axis_tlast);
			fail_count <= fails;
			pending <= selection_q.size();
		end
	end

endmodule

// ===== dv/tb_kaon_fiber_tdc_select_unit.sv =====
`timescale 1ns / 100ps

module tb_kaon_fiber_tdc_select_unit;
	import kftdc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_WORDS = 1200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	int stall_left = 0;
	int word_count = 0;
	logic steady = 1'b0;

	logic signed [ADC_W-1:0] hg_thr;
	logic signed [ADC_W-1:0] lg_thr;
	logic signed [ADC_W-1:0] prev_lg;
	logic [TDC_W-1:0] win_lo;
	logic [TDC_W-1:0] win_hi;
	logic [TDC_W-1:0] base_t;

	always #6 clk = ~clk;

	kaon_fiber_tdc_select_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	kaon_fiber_tdc_select_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count),
		.pending(pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (steady || r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!steady && $urandom_range(99) < 25) begin
			stall_left <= pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_kaon_fiber_tdc_select_unit NOT OK");
			$finish;
		end
	end

	task automatic send_fiber(input logic signed [ADC_W-1:0] hg, input logic signed [ADC_W-1:0] lg,
			input logic [HIT_FIELDS-1:0][TDC_W-1:0] hits, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'({hits, lg, hg});
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		word_count++;
	endtask

	task automatic send_random_fiber(input logic last);
		logic signed [ADC_W-1:0] hg;
		logic signed [ADC_W-1:0] lg;
		logic [HIT_FIELDS-1:0][TDC_W-1:0] hits;
		int j;
		int r;
		for (j = 0; j < HIT_FIELDS; j++) begin
			r = $urandom_range(99);
			if (r < 40)
				hits[j] = TDC_W'(int'(base_t) + int'($urandom_range(6)) - 3);
			else if (r < 65 && win_lo <= win_hi)
				hits[j] = TDC_W'($urandom_range(win_hi, win_lo));
			else if (r < 72)
				hits[j] = $urandom_range(1) ? '1 : '0;
			else
				hits[j] = TDC_W'($urandom());
		end
		r = $urandom_range(99);
		if (r < 35)
			hg = ADC_W'(int'(hg_thr) + int'($urandom_range(8)) - 4);
		else if (r < 50)
			hg = ADC_W'(int'(NONE_LEVEL) + int'($urandom_range(4)) - 2);
		else if (r < 60)
			hg = $urandom_range(1) ? -13'sd4096 : 13'sd4095;
		else
			hg = ADC_W'($urandom());
		r = $urandom_range(99);
		if (r < 15)
			lg = prev_lg;
		else if (r < 30)
			lg = ADC_W'(int'(NONE_LEVEL) + int'($urandom_range(4)) - 2);
		else if (r < 45)
			lg = ADC_W'(int'(lg_thr) + int'($urandom_range(4)) - 2);
		else if (r < 52)
			lg = $urandom_range(1) ? -13'sd4096 : 13'sd4095;
		else
			lg = ADC_W'($urandom());
		prev_lg = lg;
		send_fiber(hg, lg, hits, last);
	endtask

	task automatic send_event(input int len);
		int i;
		if (win_lo <= win_hi)
			base_t = TDC_W'($urandom_range(win_hi, win_lo));
		else
			base_t = TDC_W'($urandom());
		prev_lg = ADC_W'($urandom());
		for (i = 0; i < len; i++)
			send_random_fiber(i == len - 1);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic set_config(input logic signed [ADC_W-1:0] hgt, input logic signed [ADC_W-1:0] lgt,
			input logic [TDC_W-1:0] lo, input logic [TDC_W-1:0] hi, input logic [TDC_W-1:0] ag);
		hg_thr = hgt;
		lg_thr = lgt;
		win_lo = lo;
		win_hi = hi;
		write_reg(REG_HIGH_GAIN_THR, hgt);
		write_reg(REG_LOW_GAIN_THR, lgt);
		write_reg(REG_WINDOW_MIN, {1'($urandom_range(1)), lo});
		write_reg(REG_WINDOW_MAX, {1'($urandom_range(1)), hi});
		write_reg(REG_AGREE_LIMIT, {1'($urandom_range(1)), ag});
		if ($urandom_range(3) == 0)
			write_reg(CFG_ADDR_W'(REG_AGREE_LIMIT + 1 + $urandom_range(2)), CFG_W'($urandom()));
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		logic signed [ADC_W-1:0] hgt;
		logic signed [ADC_W-1:0] lgt;
		logic [TDC_W-1:0] lo;
		logic [TDC_W-1:0] hi;
		logic [TDC_W-1:0] ag;
		logic [TDC_W-1:0] swap;
		int r;
		r = $urandom_range(9);
		if (r < 2)
			hgt = $urandom_range(1) ? -13'sd4096 : 13'sd4095;
		else if (r < 7)
			hgt = ADC_W'(int'($urandom_range(600)) - 300);
		else
			hgt = ADC_W'($urandom());
		r = $urandom_range(9);
		if (r < 2)
			lgt = $urandom_range(1) ? -13'sd4096 : 13'sd4095;
		else if (r < 7)
			lgt = ADC_W'(int'($urandom_range(600)) - 300);
		else
			lgt = ADC_W'($urandom());
		r = $urandom_range(99);
		lo = TDC_W'($urandom());
		hi = TDC_W'($urandom());
		if (r < 15) begin
			lo = '0;
			hi = '1;
		end else if (r < 25) begin
			if (lo < hi) begin
				swap = lo;
				lo = hi;
				hi = swap;
			end
			if (lo == hi)
				lo = hi + 1'b1;
		end else if (r < 35) begin
			hi = lo;
		end else if (lo > hi) begin
			swap = lo;
			lo = hi;
			hi = swap;
		end
		r = $urandom_range(99);
		if (r < 20)
			ag = '0;
		else if (r < 30)
			ag = '1;
		else
			ag = TDC_W'($urandom_range(40));
		set_config(hgt, lgt, lo, hi, ag);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int words);
		int start;
		int r;
		start = word_count;
		while (word_count - start < words) begin
			r = $urandom_range(99);
			if (r < 70)
				send_event($urandom_range(4, 1));
			else if (r < 95)
				send_event($urandom_range(12, 5));
			else
				send_event($urandom_range(60, 13));
		end
	endtask

	initial begin
		int p;
		hg_thr = '0;
		lg_thr = '0;
		win_lo = '0;
		win_hi = '1;
		base_t = '0;
		prev_lg = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults after reset.
		send_fiber(13'sd4095, 13'sd4095, {12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0}, 1'b1);
		send_fiber(-13'sd4096, -13'sd4096, '0, 1'b1);
		send_fiber(-13'sd50, 13'sd0, {12'd7, 12'd300, 12'd5, 12'd1, 12'd2, 12'd3}, 1'b1);
		send_fiber(13'sd0, 13'sd10, {HIT_FIELDS{12'd40}}, 1'b0);
		send_fiber(13'sd1, -13'sd4096, {HIT_FIELDS{12'd41}}, 1'b1);
		send_fiber(13'sd100, 13'sd200, {HIT_FIELDS{12'd100}}, 1'b0);
		send_fiber(13'sd200, 13'sd200, {HIT_FIELDS{12'd103}}, 1'b1);
		send_fiber(13'sd10, 13'sd300, {HIT_FIELDS{12'd10}}, 1'b0);
		send_fiber(13'sd10, 13'sd500, {HIT_FIELDS{12'd2000}}, 1'b0);
		send_fiber(13'sd10, 13'sd400, {HIT_FIELDS{12'd50}}, 1'b1);
		send_fiber(13'sd10, 13'sd500, {HIT_FIELDS{12'd10}}, 1'b0);
		send_fiber(13'sd10, 13'sd500, {HIT_FIELDS{12'd20}}, 1'b1);
		send_fiber(13'sd10, -13'sd100, {HIT_FIELDS{12'd10}}, 1'b0);
		send_fiber(13'sd10, -13'sd4096, {HIT_FIELDS{12'd20}}, 1'b1);
		send_fiber(13'sd10, 13'sd50, {HIT_FIELDS{12'd0}}, 1'b0);
		send_fiber(13'sd10, -13'sd100, {HIT_FIELDS{12'd4095}}, 1'b1);
		send_fiber(13'sd10, -13'sd50, {HIT_FIELDS{12'd500}}, 1'b0);
		send_fiber(13'sd10, -13'sd60, {HIT_FIELDS{12'd900}}, 1'b1);
		settle();

		set_config(13'sd4095, -13'sd4096, 12'd4095, 12'd0, 12'd0);
		random_phase(20);
		settle();
		set_config(-13'sd4096, 13'sd4095, 12'd0, 12'd0, 12'd4095);
		random_phase(20);
		settle();

		p = 0;
		while (word_count < RANDOM_WORDS) begin
			random_config();
			steady = ($urandom_range(4) == 0);
			if (p == 2)
				send_event(260);
			if (p == 5)
				send_event(256);
			random_phase(100);
			settle();
			steady = 1'b0;
			p++;
		end

		if (fail_count == 0 && pending == 0)
			$display("tb_kaon_fiber_tdc_select_unit OK");
		else
			$display("tb_kaon_fiber_tdc_select_unit NOT OK");
		$finish;
	end

endmodule
